>>> src/hcbp_pkg.sv
// hcbp_pkg: action codes and table entry layout for the huffman code bit packer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int unsigned CodeW = 16;
  localparam int unsigned LenW  = 5;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_END    = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
  } entry_t;

  localparam logic CFG_EOF_CODE = 1'b0;
  localparam logic CFG_EOF_LEN  = 1'b1;

endpackage

`default_nettype wire

>>> src/huffman_code_bit_packer.sv
// huffman_code_bit_packer: code table memory, bit packing stage and byte emitter
// depends on hcbp_pkg
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | action_i symbol_i code_bits_i code_length_i
//  out     | output    | out_valid_o/out_stall_i | packed_byte_o last_of_item_o block_done_o
//  cfg     | input     | cfg_we_i               | cfg_idx_i cfg_data_i
//
// an encode request reads the table into a register in its accept cycle; the packing stage
// packs it once the emitter is empty or its last byte is taken, so a new request overlaps the
// last byte of the one before; the output register emits one byte per cycle unless stalled.
// a load request writes the table in its accept cycle and emits nothing.
// reset clears the pending bits and the emitter; the table is not cleared.
// a stalled output holds the emitter, which then holds the packing stage and the input.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  symbol_i,
  input  wire logic [15:0] code_bits_i,
  input  wire logic [4:0]  code_length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       packed_byte_o,
  output logic             last_of_item_o,
  output logic             block_done_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned CAP = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;

  // configuration
  logic [15:0] eof_code_q;
  logic [4:0]  eof_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eof_code_q <= '0;
      eof_len_q  <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hcbp_pkg::CFG_EOF_CODE: eof_code_q <= cfg_data_i;
        hcbp_pkg::CFG_EOF_LEN:  eof_len_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // input decode
  logic          in_acc;
  logic          in_range;
  logic          tbl_we;
  logic          tbl_re;
  logic          s1_load;
  logic [AW-1:0] addr;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_range = {1'b0, symbol_i} < 9'(SYMBOL_COUNT);
  assign addr     = symbol_i[AW-1:0];
  assign tbl_we   = in_acc && (action_i == hcbp_pkg::ACT_LOAD) && in_range;
  assign tbl_re   = in_acc && (action_i == hcbp_pkg::ACT_ENCODE) && in_range;
  assign s1_load  = tbl_re || (in_acc && (action_i == hcbp_pkg::ACT_END));

  // code table
  hcbp_pkg::entry_t mem_q [SYMBOL_COUNT];
  hcbp_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      mem_q[addr] <= '{len: code_length_i, code: code_bits_i};
    end
    if (tbl_re) begin
      rd_q <= mem_q[addr];
    end
  end

  // packing stage
  logic        s1_valid_q, s1_valid_d;
  logic        s1_end_q;
  logic [6:0]  pend_q, pend_d;
  logic [2:0]  pend_cnt_q, pend_cnt_d;
  logic [1:0]  nb_q, nb_d;
  logic [23:0] sh_q, sh_d;
  logic        end_q, end_d;
  logic        out_acc;
  logic        s1_go;

  logic [15:0] src_code;
  logic [4:0]  src_len;
  logic [4:0]  len_c;
  logic [16:0] mask;
  logic [22:0] acc;
  logic [4:0]  total;
  logic [1:0]  nb_new;
  logic [23:0] al;
  logic [22:0] rem_mask;

  assign out_acc = out_valid_o && !out_stall_i;
  assign s1_go   = s1_valid_q && ((nb_q == 2'd0) || ((nb_q == 2'd1) && !out_stall_i));
  assign in_stall_o = s1_valid_q && !s1_go;

  always_comb begin
    src_code = s1_end_q ? eof_code_q : rd_q.code;
    src_len  = s1_end_q ? eof_len_q : rd_q.len;
    len_c    = (src_len > 5'(CAP)) ? 5'(CAP) : src_len;
    mask     = (17'd1 << len_c) - 17'd1;
    acc      = (23'(pend_q) << len_c) | 23'(src_code & mask[15:0]);
    total    = {2'b00, pend_cnt_q} + len_c;
    nb_new   = s1_end_q ? (total[4:3] + 2'(total[2:0] != 3'd0)) : total[4:3];
    al       = 24'(acc) << (5'd24 - total);
    rem_mask = (23'd1 << total[2:0]) - 23'd1;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    nb_d       = nb_q;
    sh_d       = sh_q;
    end_d      = end_q;
    if (out_acc) begin
      nb_d = nb_q - 2'd1;
      sh_d = {sh_q[15:0], 8'h00};
    end
    if (s1_go) begin
      s1_valid_d = 1'b0;
      nb_d       = nb_new;
      sh_d       = al;
      end_d      = s1_end_q;
      if (s1_end_q) begin
        pend_d     = '0;
        pend_cnt_d = '0;
      end else begin
        pend_d     = 7'(acc & rem_mask);
        pend_cnt_d = total[2:0];
      end
    end
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= '0;
      pend_cnt_q <= '0;
      nb_q       <= '0;
      end_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      pend_q     <= pend_d;
      pend_cnt_q <= pend_cnt_d;
      nb_q       <= nb_d;
      end_q      <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    if (s1_load) begin
      s1_end_q <= (action_i == hcbp_pkg::ACT_END);
    end
  end

  // byte emitter
  assign out_valid_o    = (nb_q != 2'd0);
  assign packed_byte_o  = sh_q[23:16];
  assign last_of_item_o = (nb_q == 2'd1);
  assign block_done_o   = (nb_q == 2'd1) && end_q;

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && block_done_o) |-> last_of_item_o)
    else $error("block_done without last_of_item");

  a_encode_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_re |=> s1_valid_q)
    else $error("encode request lost before packing");

  a_end_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_end_q) |=> (pend_cnt_q == 3'd0))
    else $error("pending bits left after end of block");

  a_emitter_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(packed_byte_o)))
    else $error("stalled output byte changed");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for huffman_code_bit_packer, predicts every packed byte
// drives directed and random load, encode and end requests with random stalls on both sides
// depends on hcbp_pkg and huffman_code_bit_packer
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TimeoutCycles = 200000;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned HoldCycles    = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } packed_out_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  hcbp_pkg::action_e action_i = hcbp_pkg::ACT_NONE;
  logic [7:0]        symbol_i = '0;
  logic [15:0]       code_bits_i = '0;
  logic [4:0]        code_length_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        packed_byte_o;
  logic              last_of_item_o;
  logic              block_done_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = hcbp_pkg::CFG_EOF_CODE;
  logic [15:0]       cfg_data_i = '0;

  // predictor state
  hcbp_pkg::entry_t codebook [256];
  bit          loaded [256];
  logic [7:0]  loaded_syms [$];
  logic [6:0]  bit_acc = '0;
  int unsigned bit_cnt = 0;
  logic [15:0] eof_code_reg = '0;
  logic [4:0]  eof_len_reg = 5'd1;
  packed_out_t item_bytes [$];
  packed_out_t expected_bytes [$];
  packed_out_t want_byte;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_trigger = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned bytes_seen = 0;
  int unsigned blocks_seen = 0;

  huffman_code_bit_packer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .symbol_i       (symbol_i),
    .code_bits_i    (code_bits_i),
    .code_length_i  (code_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packed_byte_o  (packed_byte_o),
    .last_of_item_o (last_of_item_o),
    .block_done_o   (block_done_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // append a code msb first, collecting every byte that fills
  function automatic void shift_code(logic [15:0] cbits, logic [4:0] clen);
    int unsigned n;
    int unsigned total;
    logic [31:0] acc;
    n = (clen > 5'd16) ? 16 : clen;
    acc = ({25'd0, bit_acc} << n) | ({16'd0, cbits} & ((32'd1 << n) - 32'd1));
    total = bit_cnt + n;
    while (total >= 8) begin
      total -= 8;
      item_bytes.push_back('{data: 8'(acc >> total), last: 1'b0, done: 1'b0});
    end
    bit_acc = 7'(acc & ((32'd1 << total) - 32'd1));
    bit_cnt = total;
  endfunction

  function automatic void pack_request(hcbp_pkg::action_e act, logic [7:0] sym,
                                       logic [15:0] cbits, logic [4:0] clen);
    packed_out_t tail;
    item_bytes.delete();
    case (act)
      hcbp_pkg::ACT_LOAD: begin
        codebook[sym] = '{len: clen, code: cbits};
        if (!loaded[sym]) begin
          loaded[sym] = 1'b1;
          loaded_syms.push_back(sym);
        end
      end
      hcbp_pkg::ACT_ENCODE: shift_code(codebook[sym].code, codebook[sym].len);
      hcbp_pkg::ACT_END: begin
        shift_code(eof_code_reg, eof_len_reg);
        if (bit_cnt > 0)
          item_bytes.push_back('{data: 8'({1'b0, bit_acc} << (8 - bit_cnt)),
                                 last: 1'b0, done: 1'b0});
        bit_acc = '0;
        bit_cnt = 0;
      end
      default: ;
    endcase
    if (item_bytes.size() > 0) begin
      tail = item_bytes.pop_back();
      tail.last = 1'b1;
      tail.done = (act == hcbp_pkg::ACT_END);
      item_bytes.push_back(tail);
    end
    foreach (item_bytes[i]) expected_bytes.push_back(item_bytes[i]);
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= MaxReported) $display("cycle %0d: %s", cycle_count, msg);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_seen++;
      if (block_done_o === 1'b1) blocks_seen++;
      if (expected_bytes.size() == 0) begin
        note_error($sformatf("unexpected byte %h last %b done %b", packed_byte_o,
                             last_of_item_o, block_done_o));
      end else begin
        want_byte = expected_bytes.pop_front();
        if (packed_byte_o !== want_byte.data || last_of_item_o !== want_byte.last ||
            block_done_o !== want_byte.done)
          note_error($sformatf("expected byte %h last %b done %b, got byte %h last %b done %b",
                               want_byte.data, want_byte.last, want_byte.done,
                               packed_byte_o, last_of_item_o, block_done_o));
      end
    end
  end

  // output stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_trigger) begin
      hold_seen = hold_trigger;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_req(hcbp_pkg::action_e act, logic [7:0] sym, logic [15:0] cbits,
                          logic [4:0] clen);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    symbol_i      <= sym;
    code_bits_i   <= cbits;
    code_length_i <= clen;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pack_request(act, sym, cbits, clen);
    requests_sent++;
  endtask

  task automatic send_encode(logic [7:0] sym);
    send_req(hcbp_pkg::ACT_ENCODE, sym, 16'($urandom), 5'($urandom));
  endtask

  task automatic send_end();
    send_req(hcbp_pkg::ACT_END, 8'($urandom), 16'($urandom), 5'($urandom));
  endtask

  task automatic send_load(logic [7:0] sym);
    logic [4:0] clen;
    case ($urandom_range(9))
      0: clen = 5'($urandom_range(31, 17));
      1: clen = 5'd0;
      default: clen = 5'($urandom_range(16, 1));
    endcase
    send_req(hcbp_pkg::ACT_LOAD, sym, 16'($urandom), clen);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == hcbp_pkg::CFG_EOF_CODE) eof_code_reg = data;
    else eof_len_reg = data[4:0];
  endtask

  task automatic set_eof(logic [15:0] cbits, logic [4:0] clen);
    settle();
    write_reg(hcbp_pkg::CFG_EOF_CODE, cbits);
    write_reg(hcbp_pkg::CFG_EOF_LEN, {11'd0, clen});
  endtask

  task automatic test_codebook_extremes();
    send_req(hcbp_pkg::ACT_LOAD, 8'h00, 16'hFFFF, 5'd16);
    send_req(hcbp_pkg::ACT_LOAD, 8'hFF, 16'h0000, 5'd16);
    send_req(hcbp_pkg::ACT_LOAD, 8'h41, 16'hABCD, 5'd3);
    send_req(hcbp_pkg::ACT_LOAD, 8'h80, 16'h1234, 5'd0);
    send_req(hcbp_pkg::ACT_LOAD, 8'h7E, 16'hFFFF, 5'd31);
    send_req(hcbp_pkg::ACT_LOAD, 8'h01, 16'h0055, 5'd7);
    send_encode(8'h00);
    send_encode(8'h41);
    send_encode(8'h80);
    send_encode(8'hFF);
    send_encode(8'h7E);
    send_req(hcbp_pkg::ACT_NONE, 8'hFF, 16'hFFFF, 5'h1F);
    send_end();
    send_end();
  endtask

  task automatic test_eof_register();
    set_eof(16'h0000, 5'd0);
    send_end();
    send_encode(8'h01);
    send_end();
    set_eof(16'hFFFF, 5'd16);
    send_encode(8'h01);
    send_end();
    set_eof(16'hA5C3, 5'd31);
    send_encode(8'h41);
    send_end();
  endtask

  // mostly well-formed blocks, some without an end, plus loads and unknown actions
  task automatic test_random_blocks(int unsigned target);
    int unsigned sent_items;
    int unsigned run_len;
    int unsigned pick;
    sent_items = 0;
    set_eof(16'($urandom), 5'($urandom_range(16)));
    while (sent_items < target) begin
      run_len = $urandom_range(10, 1);
      repeat (run_len) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          send_req(hcbp_pkg::ACT_NONE, 8'($urandom), 16'($urandom), 5'($urandom));
        end else if (pick < 18) begin
          send_load(8'($urandom));
          sent_items++;
        end else begin
          send_encode(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
          sent_items++;
        end
      end
      if ($urandom_range(9) != 0) begin
        send_end();
        sent_items++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_trigger++;
    repeat (30) send_encode(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
    send_end();
  endtask

  initial begin
    send_idle_pct = 17;
    recv_idle_pct = 65;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_codebook_extremes();
    test_eof_register();
    test_random_blocks(65);
    send_idle_pct = 65;
    recv_idle_pct = 17;
    test_random_blocks(65);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_blocks(65);
    test_backpressure();
    settle();
    $display("%0d requests accepted, %0d packed bytes checked, %0d blocks closed",
             requests_sent, bytes_seen, blocks_seen);
    $display("covered code lengths 0 to 31, end codes of 0 to 16 bits, long output hold-off");
    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
